>>> hdl/c32fac_pkg.sv
// Shared types and codes for the CRC-32 frame append/check block.
// Used by the front, queue, back and top-level modules; no dependencies.
package c32fac_pkg;

  localparam int unsigned QueueDepth = 2;

  // Result kind codes
  localparam logic [1:0] KindEcho    = 2'd0;
  localparam logic [1:0] KindCrc     = 2'd1;
  localparam logic [1:0] KindVerdict = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       frame_end;
    logic       crc_good;
    logic       too_short;
  } out_t;

  typedef enum logic [1:0] {
    JobEcho,
    JobEchoCrc,
    JobVerdict
  } job_e;

  // One classified request handed from the front to the back
  typedef struct packed {
    job_e        op;
    logic [7:0]  data_byte;
    logic [31:0] crc_final;
    logic        crc_good;
    logic        too_short;
  } job_t;

endpackage

>>> hdl/c32fac_front.sv
// Front end: accepts bytes, runs the CRC and the trailing delay line, emits jobs.
// Depends on c32fac_pkg.
module c32fac_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  c32fac_pkg::in_t   in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  output logic              push_o,
  output c32fac_pkg::job_t  job_o,
  input  logic              full_i
);

  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcPreset = 32'hFFFFFFFF;

  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  logic        mode_q;
  logic [31:0] crc_q, crc_d;
  logic [7:0]  tail_q [4];
  logic [7:0]  tail_d [4];
  logic [2:0]  fill_q, fill_d;

  logic        accept;
  logic [31:0] crc_app;
  logic [31:0] crc_chk;
  logic        too_short;
  logic        crc_match;

  assign in_ready_o  = !full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !full_i;

  assign crc_app = crc_feed(crc_q, in_i.data_byte);

  // Check mode: only the byte pushed out of the delay line enters the CRC
  always_comb begin
    tail_d = tail_q;
    if (fill_q[2]) begin
      crc_chk   = crc_feed(crc_q, tail_q[0]);
      tail_d[0] = tail_q[1];
      tail_d[1] = tail_q[2];
      tail_d[2] = tail_q[3];
      tail_d[3] = in_i.data_byte;
      fill_d    = 3'd4;
    end else begin
      crc_chk               = crc_q;
      tail_d[fill_q[1:0]]   = in_i.data_byte;
      fill_d                = fill_q + 3'd1;
    end
    crc_d = mode_q ? crc_chk : crc_app;
  end

  assign too_short = !fill_d[2];
  assign crc_match = ({tail_d[3], tail_d[2], tail_d[1], tail_d[0]} == ~crc_chk);

  always_comb begin
    job_o.data_byte = in_i.data_byte;
    job_o.crc_final = ~crc_app;
    job_o.crc_good  = 1'b0;
    job_o.too_short = 1'b0;
    if (mode_q) begin
      job_o.op        = c32fac_pkg::JobVerdict;
      job_o.crc_good  = !too_short && crc_match;
      job_o.too_short = too_short;
    end else if (in_i.last_byte) begin
      job_o.op = c32fac_pkg::JobEchoCrc;
    end else begin
      job_o.op = c32fac_pkg::JobEcho;
    end
  end

  // Check mode stays silent until the last byte
  assign push_o = accept && (!mode_q || in_i.last_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      crc_q  <= CrcPreset;
      fill_q <= 3'd0;
      for (int i = 0; i < 4; i++) tail_q[i] <= 8'd0;
    end else if (cfg_valid_i) begin
      // a mode write drops any message in progress
      mode_q <= cfg_data_i;
      crc_q  <= CrcPreset;
      fill_q <= 3'd0;
      for (int i = 0; i < 4; i++) tail_q[i] <= 8'd0;
    end else if (accept) begin
      if (in_i.last_byte) begin
        crc_q  <= CrcPreset;
        fill_q <= 3'd0;
        for (int i = 0; i < 4; i++) tail_q[i] <= 8'd0;
      end else begin
        crc_q <= crc_d;
        if (mode_q) begin
          fill_q <= fill_d;
          tail_q <= tail_d;
        end
      end
    end
  end

endmodule

>>> hdl/c32fac_queue.sv
// Small job queue between front and back so each side can stall on its own.
// Depends on c32fac_pkg.
module c32fac_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  c32fac_pkg::job_t  job_i,
  output logic              full_o,
  input  logic              pop_i,
  output c32fac_pkg::job_t  job_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = $clog2(c32fac_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(c32fac_pkg::QueueDepth + 1);

  c32fac_pkg::job_t slot_q [c32fac_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(c32fac_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(c32fac_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(c32fac_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> hdl/c32fac_back.sv
// Back end: turns queued jobs into results, sequencing the four CRC bytes.
// Depends on c32fac_pkg.
module c32fac_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  c32fac_pkg::job_t  job_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output c32fac_pkg::out_t  out_o
);

  typedef enum logic {
    StJob,
    StCrc
  } state_e;

  state_e           state_q, state_d;
  logic             out_valid_q, out_valid_d;
  c32fac_pkg::out_t out_q, out_d;
  logic [31:0]      crc_q, crc_d;
  logic [1:0]       idx_q, idx_d;
  logic             advance;

  // output slot is free or being taken this cycle
  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && (state_q == StJob) && !empty_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    crc_d       = crc_q;
    idx_d       = idx_q;
    if (advance) begin
      unique case (state_q)
        StCrc: begin
          out_valid_d     = 1'b1;
          out_d.out_byte  = 8'(crc_q >> {idx_q, 3'b000});
          out_d.kind      = c32fac_pkg::KindCrc;
          out_d.frame_end = (idx_q == 2'd3);
          out_d.crc_good  = 1'b0;
          out_d.too_short = 1'b0;
          idx_d           = idx_q + 2'd1;
          if (idx_q == 2'd3) state_d = StJob;
        end
        default: begin
          if (!empty_i) begin
            out_valid_d     = 1'b1;
            out_d.crc_good  = 1'b0;
            out_d.too_short = 1'b0;
            out_d.frame_end = 1'b0;
            unique case (job_i.op)
              c32fac_pkg::JobVerdict: begin
                out_d.out_byte  = 8'd0;
                out_d.kind      = c32fac_pkg::KindVerdict;
                out_d.frame_end = 1'b1;
                out_d.crc_good  = job_i.crc_good;
                out_d.too_short = job_i.too_short;
              end
              c32fac_pkg::JobEchoCrc: begin
                out_d.out_byte = job_i.data_byte;
                out_d.kind     = c32fac_pkg::KindEcho;
                crc_d          = job_i.crc_final;
                idx_d          = 2'd0;
                state_d        = StCrc;
              end
              default: begin
                out_d.out_byte = job_i.data_byte;
                out_d.kind     = c32fac_pkg::KindEcho;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StJob;
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_q       <= '0;
      crc_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      out_q       <= out_d;
      crc_q       <= crc_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> hdl/crc32_frame_append_check.sv
// Top level of the CRC-32 frame append/check block.
// Depends on c32fac_pkg, c32fac_front, c32fac_queue and c32fac_back.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | in_i  (data_byte, last_byte)
//   out     | output    | out_valid_o / out_ready_i| out_o (out_byte, kind, frame_end,
//           |           |                          |        crc_good, too_short)
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (mode)
//
// One byte per cycle enters while the job queue is not full; the CRC update is an unrolled
// eight-bit step in the front. A result passes through the job queue and the output register
// after its byte is accepted; a byte marked last in append mode yields five results (echo
// plus four CRC bytes), absorbed by the two-entry job queue before the input stalls.
// Reset sets append mode and the CRC preset; a mode write also clears the message state.
// Either side may stall at any time; the queue and output register hold requests.
module crc32_frame_append_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  c32fac_pkg::in_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output c32fac_pkg::out_t  out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  logic             push, full, pop, empty;
  c32fac_pkg::job_t job_in, job_out;

  c32fac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  c32fac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty)
  );

  c32fac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.kind == c32fac_pkg::KindEcho ||
                     out_o.kind == c32fac_pkg::KindCrc ||
                     out_o.kind == c32fac_pkg::KindVerdict))
    else $error("illegal result kind");

  a_verdict_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.kind == c32fac_pkg::KindVerdict) |->
      (out_o.frame_end && out_o.out_byte == 8'd0 && !(out_o.crc_good && out_o.too_short)))
    else $error("malformed verdict");

  a_echo_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.kind == c32fac_pkg::KindEcho) |->
      (!out_o.frame_end && !out_o.crc_good && !out_o.too_short))
    else $error("malformed echo");

  a_crc_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_o.kind == c32fac_pkg::KindCrc && !out_o.frame_end)
      |=> (out_valid_o && out_o.kind == c32fac_pkg::KindCrc))
    else $error("CRC byte sequence broken");

endmodule

>>> sim/tb_crc32_frame_append_check.sv
// Self-checking testbench for crc32_frame_append_check: byte streams in append and check mode,
// with a built-in CRC-32 framer predicting echoes, CRC bytes and verdicts.
// Depends on c32fac_pkg and the RTL of the block.
module tb_crc32_frame_append_check;

  localparam int unsigned RandomBytes  = 280;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned CycleLimit   = 200000;
  localparam int          NumRows      = 22;

  localparam logic        ModeAppend = 1'b0;
  localparam logic        ModeCheck  = 1'b1;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcPreset  = 32'hFFFFFFFF;

  typedef struct packed {
    logic             mode;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic             typed;
    c32fac_pkg::out_t first;
  } dir_row_t;

  // first is the first result of the row, typed in only where it is obvious
  dir_row_t dir_rows [NumRows] = '{
    '{ModeAppend, 8'h00, 1'b1, 1'b1, '{8'h00, c32fac_pkg::KindEcho, 1'b0, 1'b0, 1'b0}},
    '{ModeAppend, 8'hFF, 1'b0, 1'b1, '{8'hFF, c32fac_pkg::KindEcho, 1'b0, 1'b0, 1'b0}},
    '{ModeAppend, 8'hFF, 1'b0, 1'b0, '0},
    '{ModeAppend, 8'hA5, 1'b1, 1'b1, '{8'hA5, c32fac_pkg::KindEcho, 1'b0, 1'b0, 1'b0}},
    '{ModeAppend, 8'h5A, 1'b0, 1'b1, '{8'h5A, c32fac_pkg::KindEcho, 1'b0, 1'b0, 1'b0}},
    '{ModeCheck,  8'hC3, 1'b1, 1'b1, '{8'h00, c32fac_pkg::KindVerdict, 1'b1, 1'b0, 1'b1}},
    '{ModeCheck,  8'h01, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'h02, 1'b1, 1'b1, '{8'h00, c32fac_pkg::KindVerdict, 1'b1, 1'b0, 1'b1}},
    '{ModeCheck,  8'h55, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'hAA, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'h80, 1'b1, 1'b1, '{8'h00, c32fac_pkg::KindVerdict, 1'b1, 1'b0, 1'b1}},
    // empty payload: its CRC is zero, so four zero bytes check good
    '{ModeCheck,  8'h00, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'h00, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'h00, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'h00, 1'b1, 1'b1, '{8'h00, c32fac_pkg::KindVerdict, 1'b1, 1'b1, 1'b0}},
    '{ModeCheck,  8'hFF, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'hFF, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'hFF, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'hFF, 1'b1, 1'b1, '{8'h00, c32fac_pkg::KindVerdict, 1'b1, 1'b0, 1'b0}},
    '{ModeCheck,  8'h11, 1'b0, 1'b0, '0},
    '{ModeCheck,  8'h22, 1'b0, 1'b0, '0},
    // mode write drops the open check message
    '{ModeAppend, 8'h33, 1'b1, 1'b1, '{8'h33, c32fac_pkg::KindEcho, 1'b0, 1'b0, 1'b0}}
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  c32fac_pkg::in_t  in_i        = '0;
  logic             out_ready_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_data_i  = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  c32fac_pkg::out_t out_o;
  logic             cfg_ready_o;

  // framer state mirrored by the predictor
  logic             mode_q;
  logic [31:0]      crc_acc;
  logic [7:0]       tail_bytes [4];
  logic [2:0]       tail_cnt;
  c32fac_pkg::out_t step_out [$];
  c32fac_pkg::out_t pending_results [$];

  logic quiet      = 1'b0;
  logic hold_start = 1'b0;
  int   mismatches    = 0;
  int   results_seen  = 0;
  int   random_bytes  = 0;
  int   frames_append = 0;
  int   frames_check  = 0;
  int   cycle_count   = 0;

  crc32_frame_append_check DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic c32fac_pkg::out_t result_of(logic [7:0] ob, logic [1:0] k, logic fe,
                                                 logic good, logic shrt);
    c32fac_pkg::out_t r;
    r.out_byte  = ob;
    r.kind      = k;
    r.frame_end = fe;
    r.crc_good  = good;
    r.too_short = shrt;
    return r;
  endfunction

  function automatic void clear_frame();
    crc_acc = CrcPreset;
    foreach (tail_bytes[i]) tail_bytes[i] = 8'h00;
    tail_cnt = 3'd0;
  endfunction

  // Advance the framer by one byte and leave its results in step_out
  function automatic void frame_step(c32fac_pkg::in_t req);
    logic [31:0] fin;
    step_out.delete();
    if (mode_q == ModeAppend) begin
      crc_acc = crc_byte(crc_acc, req.data_byte);
      step_out.push_back(result_of(req.data_byte, c32fac_pkg::KindEcho, 1'b0, 1'b0, 1'b0));
      if (req.last_byte) begin
        fin = ~crc_acc;
        for (int i = 0; i < 4; i++)
          step_out.push_back(result_of(fin[8*i +: 8], c32fac_pkg::KindCrc, i == 3,
                                       1'b0, 1'b0));
        clear_frame();
      end
    end else begin
      // only a byte pushed out of the tail enters the CRC
      if (tail_cnt >= 3'd4) begin
        crc_acc = crc_byte(crc_acc, tail_bytes[0]);
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = tail_bytes[2];
        tail_bytes[2] = tail_bytes[3];
        tail_bytes[3] = req.data_byte;
      end else begin
        tail_bytes[tail_cnt[1:0]] = req.data_byte;
        tail_cnt = tail_cnt + 3'd1;
      end
      if (req.last_byte) begin
        fin = ~crc_acc;
        if (tail_cnt < 3'd4)
          step_out.push_back(result_of(8'h00, c32fac_pkg::KindVerdict, 1'b1, 1'b0, 1'b1));
        else
          step_out.push_back(result_of(8'h00, c32fac_pkg::KindVerdict, 1'b1,
              {tail_bytes[3], tail_bytes[2], tail_bytes[1], tail_bytes[0]} == fin, 1'b0));
        clear_frame();
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one request; hold valid and payload until accepted
  task automatic send_byte(input c32fac_pkg::in_t req, input logic typed,
                           input c32fac_pkg::out_t first);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_i       = req;
    do @(posedge clk_i); while (!in_ready_o);
    frame_step(req);
    if (typed) step_out[0] = first;
    foreach (step_out[i]) pending_results.push_back(step_out[i]);
    if (req.last_byte) begin
      if (mode_q == ModeAppend) frames_append++;
      else frames_check++;
    end
    @(negedge clk_i);
  endtask

  // Write mode only once the block has drained
  task automatic write_mode(input logic m);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = m;
    do @(posedge clk_i); while (!cfg_ready_o);
    mode_q = m;
    clear_frame();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin : result_check
    c32fac_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_byte %0h kind %0h", out_o.out_byte, out_o.kind);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", want.out_byte, out_o.out_byte);
        check_field("kind", want.kind, out_o.kind);
        check_field("frame_end", want.frame_end, out_o.frame_end);
        check_field("crc_good", want.crc_good, out_o.crc_good);
        check_field("too_short", want.too_short, out_o.too_short);
      end
    end
  end

  initial begin : out_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_start) begin
        hold_left  = HoldCycles;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = quiet || $urandom_range(99) >= 15;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("** crc32_frame_append_check: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]      msg [$];
    logic [31:0]     crc;
    logic            m;
    logic            open_end;
    int              phase;
    int              n_msgs;
    int              len;
    int              pick;
    int              idx;
    int              drain;
    c32fac_pkg::in_t req;

    mode_q = ModeAppend;
    clear_frame();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != mode_q) write_mode(dir_rows[r].mode);
      req.data_byte = dir_rows[r].data_byte;
      req.last_byte = dir_rows[r].last_byte;
      send_byte(req, dir_rows[r].typed, dir_rows[r].first);
    end

    phase = 0;
    while (random_bytes < RandomBytes) begin
      phase++;
      m = (phase == 1) ? ModeAppend : 1'($urandom_range(1));
      write_mode(m);
      quiet = (phase == 2);
      // back up the output while append frames keep coming
      if (phase == 1) hold_start = 1'b1;
      n_msgs = $urandom_range(2, 6);
      for (int k = 0; k < n_msgs; k++) begin
        if (phase == 3 && k == 1) begin
          in_valid_i = 1'b0;
          while (pending_results.size() != 0) @(negedge clk_i);
        end
        msg.delete();
        if (m == ModeAppend) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          repeat (len) msg.push_back(8'($urandom_range(255)));
        end else begin
          // mostly valid frames, then corrupted, short and random ones
          pick = $urandom_range(99);
          len  = (pick < 75) ? $urandom_range(0, 12) :
                 (pick < 85) ? $urandom_range(1, 3) : $urandom_range(4, 12);
          repeat (len) msg.push_back(8'($urandom_range(255)));
          if (pick < 75) begin
            crc = CrcPreset;
            foreach (msg[i]) crc = crc_byte(crc, msg[i]);
            crc = ~crc;
            for (int i = 0; i < 4; i++) msg.push_back(crc[8*i +: 8]);
            if (pick >= 60) begin
              idx      = $urandom_range(msg.size() - 1);
              msg[idx] = msg[idx] ^ (8'h01 << $urandom_range(7));
            end
          end
        end
        // leave the final frame of a phase open now and then
        open_end = (k == n_msgs - 1) && ($urandom_range(3) == 0);
        foreach (msg[i]) begin
          req.data_byte = msg[i];
          req.last_byte = (i == msg.size() - 1) && !open_end;
          send_byte(req, 1'b0, '0);
          random_bytes++;
        end
      end
    end
    quiet      = 1'b0;
    in_valid_i = 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < DrainLimit) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SettleCycles * 2) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Sent %0d table and %0d random bytes: %0d append and %0d check frames.",
             NumRows, random_bytes, frames_append, frames_check);
    $display("Compared %0d results over %0d mode phases, %0d failures.",
             results_seen, phase, mismatches);
    if (mismatches == 0) begin
      $display("** crc32_frame_append_check: PASSED **");
    end else begin
      $display("** crc32_frame_append_check: FAILED **");
    end
    $finish;
  end

endmodule
